FILE: sv/assert_macros.svh
// Assertion shorthands used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define AFC_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define AFC_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

// Next-cycle consequence of reset itself.
`define AFC_ASSERT_RESET(lbl, post, msg) \
   lbl: assert property (@(posedge clock) reset |=> (post)) \
      else $error(msg);

`endif

FILE: sv/afc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package afc_pkg;

   localparam int COORD_W     = 32;
   localparam int PROD_W      = 2 * COORD_W;
   localparam int CLIP_W      = PROD_W + 2;
   localparam int ONE_SHIFT   = 16;
   localparam int AXIS_N      = 3;
   localparam int ROW_N       = 4;
   localparam int CORNER_N    = 8;
   localparam int PLANE_N     = 6;
   localparam int REG_N       = 8;
   localparam int REG_W       = 64;
   localparam int REG_SEL_W   = 3;
   localparam int CSR_INDEX_W = 4;
   localparam int REQ_DATA_W  = 2 * AXIS_N * COORD_W;
   localparam int RSP_DATA_W  = 8;

   localparam int ROW_X = 0;
   localparam int ROW_Y = 1;
   localparam int ROW_Z = 2;
   localparam int ROW_W = 3;
   localparam int COL_ONE = 3;

   localparam int PLANE_LEFT   = 0;
   localparam int PLANE_RIGHT  = 1;
   localparam int PLANE_BOTTOM = 2;
   localparam int PLANE_TOP    = 3;
   localparam int PLANE_NEAR   = 4;
   localparam int PLANE_FAR    = 5;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [CLIP_W-1:0]  clip_type;
   typedef logic [PLANE_N-1:0]        mask_type;
   typedef logic [CSR_INDEX_W-1:0]    csr_index_type;
   typedef logic [REG_W-1:0]          csr_data_type;

   typedef coord_type [ROW_N-1:0][ROW_N-1:0] matrix_type;

   typedef struct packed {
      coord_type [AXIS_N-1:0] hi;
      coord_type [AXIS_N-1:0] lo;
   } box_type;

   typedef struct packed {
      prod_type [ROW_N-1:0][AXIS_N-1:0][1:0] term;
      prod_type [ROW_N-1:0]                  bias;
   } prod_set_type;

   typedef clip_type [CORNER_N-1:0][ROW_N-1:0] clip_set_type;

endpackage
`default_nettype wire

FILE: sv/afc_csr_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module afc_csr_regs (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  afc_pkg::csr_index_type csr_index,
   input  afc_pkg::csr_data_type  csr_data,
   output afc_pkg::matrix_type    matrix
);
   import afc_pkg::*;

   logic [REG_N-1:0][REG_W-1:0] regs_ff;
   logic                        wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && (csr_index < CSR_INDEX_W'(REG_N));

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else if (wr_en) begin
         regs_ff[csr_index[REG_SEL_W-1:0]] <= csr_data;
      end
   end

   for (genvar r = 0; r < ROW_N; r++) begin : g_row
      for (genvar c = 0; c < ROW_N; c++) begin : g_col
         assign matrix[r][c] = regs_ff[r * 2 + (c >> 1)][(c & 1) * COORD_W +: COORD_W];
      end
   end

endmodule
`default_nettype wire

FILE: sv/afc_product_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module afc_product_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  afc_pkg::box_type      box,
   input  afc_pkg::matrix_type   matrix,
   output logic                  out_valid,
   input  logic                  out_ready,
   output afc_pkg::prod_set_type prod
);
   import afc_pkg::*;

   logic         valid_ff;
   prod_set_type prod_ff;
   prod_set_type prod_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign prod      = prod_ff;

   for (genvar r = 0; r < ROW_N; r++) begin : g_row
      for (genvar a = 0; a < AXIS_N; a++) begin : g_axis
         assign prod_in.term[r][a][0] = PROD_W'($signed(matrix[r][a]) * $signed(box.lo[a]));
         assign prod_in.term[r][a][1] = PROD_W'($signed(matrix[r][a]) * $signed(box.hi[a]));
      end
      assign prod_in.bias[r] = {{(PROD_W - COORD_W - ONE_SHIFT){matrix[r][COL_ONE][COORD_W-1]}},
                                matrix[r][COL_ONE], {ONE_SHIFT{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/afc_corner_sum.sv
`timescale 1ns / 1ps
`default_nettype none
module afc_corner_sum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  afc_pkg::prod_set_type prod,
   output logic                  out_valid,
   input  logic                  out_ready,
   output afc_pkg::clip_set_type clip
);
   import afc_pkg::*;

   logic         valid_ff;
   clip_set_type clip_ff;
   clip_set_type clip_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign clip      = clip_ff;

   for (genvar c = 0; c < CORNER_N; c++) begin : g_corner
      localparam int SX = (c >> 2) & 1;
      localparam int SY = (c >> 1) & 1;
      localparam int SZ = c & 1;
      for (genvar r = 0; r < ROW_N; r++) begin : g_row
         assign clip_in[c][r] = CLIP_W'($signed(prod.term[r][ROW_X][SX]))
                              + CLIP_W'($signed(prod.term[r][ROW_Y][SY]))
                              + CLIP_W'($signed(prod.term[r][ROW_Z][SZ]))
                              + CLIP_W'($signed(prod.bias[r]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         clip_ff <= clip_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/afc_plane_test.sv
`timescale 1ns / 1ps
`default_nettype none
module afc_plane_test (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  afc_pkg::clip_set_type clip,
   output logic                  out_valid,
   input  logic                  out_ready,
   output afc_pkg::mask_type     reject
);
   import afc_pkg::*;

   logic                      valid_ff;
   mask_type                  reject_ff;
   mask_type                  reject_in;
   mask_type [CORNER_N-1:0]   outside;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign reject    = reject_ff;

   for (genvar c = 0; c < CORNER_N; c++) begin : g_corner
      logic signed [CLIP_W:0] x_sum;
      logic signed [CLIP_W:0] y_sum;
      clip_type               cx;
      clip_type               cy;
      clip_type               cz;
      clip_type               cw;

      assign cx    = $signed(clip[c][ROW_X]);
      assign cy    = $signed(clip[c][ROW_Y]);
      assign cz    = $signed(clip[c][ROW_Z]);
      assign cw    = $signed(clip[c][ROW_W]);
      assign x_sum = (CLIP_W + 1)'(cx) + (CLIP_W + 1)'(cw);
      assign y_sum = (CLIP_W + 1)'(cy) + (CLIP_W + 1)'(cw);

      assign outside[c][PLANE_LEFT]   = x_sum[CLIP_W];
      assign outside[c][PLANE_RIGHT]  = cx > cw;
      assign outside[c][PLANE_BOTTOM] = y_sum[CLIP_W];
      assign outside[c][PLANE_TOP]    = cy > cw;
      assign outside[c][PLANE_NEAR]   = cz[CLIP_W-1];
      assign outside[c][PLANE_FAR]    = cz > cw;
   end

   always_comb begin
      reject_in = '1;
      for (int c = 0; c < CORNER_N; c++) begin
         reject_in = reject_in & outside[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         reject_ff <= reject_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/aabb_frustum_cull_test.sv
`timescale 1ns / 1ps
`default_nettype none
// Clip-space frustum rejection of one world-space box per word. A box enters with its
// minimum and maximum corners in signed Q16.16 and leaves, through the product, sum
// and compare registers, as a visible flag and a six-bit mask of the planes that
// reject all eight corners. One box is taken every cycle unless the result side stalls:
// the three register stages (24 parallel 32x32 multipliers, the per-corner clip sums,
// then the plane compares) each load when empty or when the next one takes its box and
// hold under backpressure. The 4x4 view-projection matrix, loaded through the csr channel
// as two Q16.16 elements per 64-bit register, resets to zero, leaving every box visible.
module aabb_frustum_cull_test (
   input  logic                             clock,
   input  logic                             reset,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [afc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // visible, reject_planes[5:0], one zero pad bit
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [afc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  afc_pkg::csr_index_type           csr_index,
   input  afc_pkg::csr_data_type            csr_data
);
   import afc_pkg::*;

   box_type      box;
   matrix_type   matrix;
   prod_set_type prod;
   clip_set_type clip;
   mask_type     reject;
   logic         prod_valid;
   logic         prod_ready;
   logic         clip_valid;
   logic         clip_ready;

   for (genvar a = 0; a < AXIS_N; a++) begin : g_unpack
      assign box.lo[a] = req_tdata[a * COORD_W +: COORD_W];
      assign box.hi[a] = req_tdata[(a + AXIS_N) * COORD_W +: COORD_W];
   end

   afc_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .matrix    (matrix)
   );

   afc_product_stage u_product (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .box       (box),
      .matrix    (matrix),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .prod      (prod)
   );

   afc_corner_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .prod      (prod),
      .out_valid (clip_valid),
      .out_ready (clip_ready),
      .clip      (clip)
   );

   afc_plane_test u_test (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (clip_valid),
      .in_ready  (clip_ready),
      .clip      (clip),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .reject    (reject)
   );

   assign rsp_tdata = {1'b0, reject, (reject == '0)};

endmodule
`default_nettype wire

FILE: sv/afc_port_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module afc_port_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [afc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import afc_pkg::*;

   `AFC_ASSERT_RESET(a_reset_empty, !rsp_tvalid, "result word valid straight after reset")
   `AFC_ASSERT_RESET(a_reset_ready, req_tready, "request side not ready straight after reset")
   `AFC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result word changed")
   `AFC_ASSERT_NOW(a_visible_mask, rsp_tvalid, rsp_tdata[0] == (rsp_tdata[PLANE_N:1] == '0), "visible flag disagrees with plane mask")
   `AFC_ASSERT_NOW(a_pad_zero, rsp_tvalid, !rsp_tdata[RSP_DATA_W-1], "result pad bit set")

endmodule

bind aabb_frustum_cull_test afc_port_checker u_port_checker (.*);
`default_nettype wire

FILE: dv/tb_aabb_frustum_cull_test.sv
`timescale 1ns / 1ps
module tb_aabb_frustum_cull_test;
   import afc_pkg::*;

   localparam int SUM_W = 80;
   localparam int ONE_Q = 32'sh0001_0000;
   localparam int GAP_PCT = 47;
   localparam int BOTH_PCT = 33;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BOXES = 180;
   localparam int TAIL_CYCLES = 8;
   localparam coord_type MOST_NEG = 32'sh8000_0000;
   localparam coord_type MOST_POS = 32'sh7FFF_FFFF;

   typedef enum {PACE_STEADY, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH} pace_type;
   typedef enum {MAT_ZERO, MAT_IDENTITY, MAT_ORTHO, MAT_PERSPECTIVE, MAT_SMALL, MAT_FULL,
                 MAT_EXTREME} mat_kind_type;
   typedef logic [REQ_DATA_W-1:0] box_word_type;
   typedef logic signed [SUM_W-1:0] exact_sum_type;

   typedef struct packed {
      logic     visible;
      mask_type reject_planes;
   } cull_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   box_word_type req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = '0;
   csr_data_type csr_data = '0;

   coord_type view_mat [ROW_N][ROW_N] = '{default: '0};
   box_word_type box_queue [$];
   cull_result_type verdict_queue [$];
   int sender_gap_pct = 0;
   int receiver_stall_pct = 0;
   int boxes_sent = 0;
   int verdicts_checked = 0;
   int culled_count = 0;
   int matrix_loads = 0;
   int fail_count = 0;
   int idle_cycles = 0;
   mask_type planes_seen = '0;

   aabb_frustum_cull_test uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit chance(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic coord_type q_rand(input int lo, input int hi);
      return coord_type'(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   function automatic box_word_type pack_box(input coord_type min_x, input coord_type min_y,
                                             input coord_type min_z, input coord_type max_x,
                                             input coord_type max_y, input coord_type max_z);
      return {max_z, max_y, max_x, min_z, min_y, min_x};
   endfunction

   function automatic cull_result_type predict_cull(input box_word_type word);
      coord_type lo_c [AXIS_N];
      coord_type hi_c [AXIS_N];
      coord_type crn [AXIS_N];
      exact_sum_type clip [ROW_N];
      mask_type outside;
      mask_type common;
      cull_result_type res;
      common = '1;
      for (int a = 0; a < AXIS_N; a++) begin
         lo_c[a] = word[a*COORD_W +: COORD_W];
         hi_c[a] = word[(a+AXIS_N)*COORD_W +: COORD_W];
      end
      for (int c = 0; c < CORNER_N; c++) begin
         crn[0] = c[2] ? hi_c[0] : lo_c[0];
         crn[1] = c[1] ? hi_c[1] : lo_c[1];
         crn[2] = c[0] ? hi_c[2] : lo_c[2];
         for (int r = 0; r < ROW_N; r++) begin
            clip[r] = exact_sum_type'(view_mat[r][COL_ONE]) <<< ONE_SHIFT;
            for (int k = 0; k < AXIS_N; k++)
               clip[r] = clip[r] + exact_sum_type'(view_mat[r][k]) * exact_sum_type'(crn[k]);
         end
         outside = '0;
         outside[PLANE_LEFT]   = (clip[ROW_X] + clip[ROW_W]) < 0;
         outside[PLANE_RIGHT]  = (clip[ROW_X] - clip[ROW_W]) > 0;
         outside[PLANE_BOTTOM] = (clip[ROW_Y] + clip[ROW_W]) < 0;
         outside[PLANE_TOP]    = (clip[ROW_Y] - clip[ROW_W]) > 0;
         outside[PLANE_NEAR]   = clip[ROW_Z] < 0;
         outside[PLANE_FAR]    = (clip[ROW_Z] - clip[ROW_W]) > 0;
         common &= outside;
      end
      res.reject_planes = common;
      res.visible = (common == '0);
      return res;
   endfunction

   function automatic coord_type pick_extreme();
      case ($urandom_range(0, 4))
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return '0;
         3: return ONE_Q;
         default: return -ONE_Q;
      endcase
   endfunction

   function automatic box_word_type make_box();
      coord_type lo_c [AXIS_N];
      coord_type hi_c [AXIS_N];
      coord_type mid;
      coord_type half;
      int shape;
      shape = $urandom_range(0, 9);
      for (int a = 0; a < AXIS_N; a++) begin
         mid = q_rand(-4 * ONE_Q, 4 * ONE_Q);
         half = (shape == 9) ? '0 : q_rand(0, 2 * ONE_Q);
         lo_c[a] = mid - half;
         hi_c[a] = mid + half;
         if (shape == 6) begin
            lo_c[a] = mid + half;
            hi_c[a] = mid - half;
         end else if (shape == 7) begin
            lo_c[a] = $urandom;
            hi_c[a] = $urandom;
         end else if (shape == 8) begin
            lo_c[a] = pick_extreme();
            hi_c[a] = pick_extreme();
         end
      end
      return pack_box(lo_c[0], lo_c[1], lo_c[2], hi_c[0], hi_c[1], hi_c[2]);
   endfunction

   function automatic coord_type make_coef(input mat_kind_type kind, input int row,
                                           input int col);
      case (kind)
         MAT_IDENTITY: return (row == col) ? ONE_Q : 0;
         MAT_ORTHO: begin
            if (row == ROW_W) return (col == COL_ONE) ? ONE_Q : 0;
            if (row == col) return q_rand(ONE_Q / 4, 2 * ONE_Q);
            if (col == COL_ONE) return q_rand(-ONE_Q, ONE_Q);
            return 0;
         end
         MAT_PERSPECTIVE: begin
            if (row == ROW_W) return (col == ROW_Z) ? ONE_Q : 0;
            if (row == ROW_Z && col == COL_ONE) return q_rand(-ONE_Q, 0);
            if (row == ROW_Z && col == ROW_Z) return q_rand(ONE_Q, 3 * ONE_Q / 2);
            if (row == col) return q_rand(ONE_Q / 2, 2 * ONE_Q);
            return 0;
         end
         MAT_SMALL: return q_rand(-2 * ONE_Q, 2 * ONE_Q);
         MAT_FULL: return $urandom;
         MAT_EXTREME: return $urandom_range(0, 1) ? MOST_POS : MOST_NEG;
         default: return 0;
      endcase
   endfunction

   task automatic csr_write(input csr_index_type idx, input csr_data_type val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < REG_N) begin
         view_mat[idx / 2][2 * (idx % 2)] = val[COORD_W-1:0];
         view_mat[idx / 2][2 * (idx % 2) + 1] = val[REG_W-1:COORD_W];
      end
   endtask

   task automatic load_view_matrix(input mat_kind_type kind);
      csr_data_type val;
      for (int row = 0; row < ROW_N; row++)
         for (int half = 0; half < 2; half++) begin
            val = {make_coef(kind, row, 2 * half + 1), make_coef(kind, row, 2 * half)};
            csr_write(csr_index_type'(2 * row + half), val);
         end
      // unmapped index: must leave the matrix alone
      csr_write(csr_index_type'($urandom_range(REG_N, 2 ** CSR_INDEX_W - 1)),
                {$urandom, $urandom});
      csr_valid <= 1'b0;
      matrix_loads++;
   endtask

   task automatic set_pace(input pace_type pace);
      sender_gap_pct = (pace == PACE_SENDER_GAPS) ? GAP_PCT :
                       (pace == PACE_BOTH) ? BOTH_PCT : 0;
      receiver_stall_pct = (pace == PACE_RECEIVER_STALLS) ? GAP_PCT :
                           (pace == PACE_BOTH) ? BOTH_PCT : 0;
   endtask

   task automatic wait_drained();
      while (box_queue.size() != 0 || req_tvalid || verdict_queue.size() != 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            verdict_queue.push_back(predict_cull(req_tdata));
            boxes_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (box_queue.size() != 0 && !chance(sender_gap_pct)) begin
               req_tdata <= box_queue.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : verdict_check
      cull_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_queue.size() == 0) begin
               $error("result word with no box outstanding: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = verdict_queue.pop_front();
               verdicts_checked++;
               if (!want.visible) culled_count++;
               planes_seen |= want.reject_planes;
               if (rsp_tdata[0] !== want.visible) begin
                  $error("visible: expected %0b, actual %0b", want.visible, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tdata[PLANE_N:1] !== want.reject_planes) begin
                  $error("reject_planes: expected %b, actual %b", want.reject_planes,
                         rsp_tdata[PLANE_N:1]);
                  fail_count++;
               end
            end
         end
         rsp_tready <= !chance(receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("aabb_frustum_cull_test: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : sequencer
      mat_kind_type plan [9];
      plan = '{MAT_ORTHO, MAT_PERSPECTIVE, MAT_SMALL, MAT_FULL, MAT_EXTREME, MAT_ORTHO,
               MAT_PERSPECTIVE, MAT_SMALL, MAT_ZERO};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // matrix still at reset: everything visible
      @(negedge clock);
      set_pace(PACE_STEADY);
      box_queue.push_back(pack_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG));
      box_queue.push_back(pack_box(MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS));
      box_queue.push_back(pack_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS));
      wait_drained();

      @(posedge clock);
      load_view_matrix(MAT_IDENTITY);
      @(negedge clock);
      box_queue.push_back(pack_box(-ONE_Q/2, -ONE_Q/2, ONE_Q/4, ONE_Q/2, ONE_Q/2, 3*ONE_Q/4));
      box_queue.push_back(pack_box(-3*ONE_Q, -ONE_Q/2, ONE_Q/4, -2*ONE_Q, ONE_Q/2, 3*ONE_Q/4));
      box_queue.push_back(pack_box(2*ONE_Q, -ONE_Q/2, ONE_Q/4, 3*ONE_Q, ONE_Q/2, 3*ONE_Q/4));
      box_queue.push_back(pack_box(-ONE_Q/2, -3*ONE_Q, ONE_Q/4, ONE_Q/2, -2*ONE_Q, 3*ONE_Q/4));
      box_queue.push_back(pack_box(-ONE_Q/2, 2*ONE_Q, ONE_Q/4, ONE_Q/2, 3*ONE_Q, 3*ONE_Q/4));
      box_queue.push_back(pack_box(-ONE_Q/2, -ONE_Q/2, -2*ONE_Q, ONE_Q/2, ONE_Q/2, -ONE_Q));
      box_queue.push_back(pack_box(-ONE_Q/2, -ONE_Q/2, 2*ONE_Q, ONE_Q/2, ONE_Q/2, 3*ONE_Q));
      box_queue.push_back(pack_box(2*ONE_Q, 2*ONE_Q, 2*ONE_Q, 3*ONE_Q, 3*ONE_Q, 3*ONE_Q));
      // touching the left plane exactly stays visible
      box_queue.push_back(pack_box(-2*ONE_Q, -ONE_Q/2, 0, -ONE_Q, ONE_Q/2, ONE_Q));
      box_queue.push_back(pack_box(-3*ONE_Q, -3*ONE_Q, -3*ONE_Q, 3*ONE_Q, 3*ONE_Q, 3*ONE_Q));
      // minimum above maximum, taken as given
      box_queue.push_back(pack_box(3*ONE_Q, -ONE_Q/2, ONE_Q/4, 2*ONE_Q, ONE_Q/2, 3*ONE_Q/4));
      box_queue.push_back(pack_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG));
      box_queue.push_back(pack_box(MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS));
      box_queue.push_back(pack_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS));
      box_queue.push_back(pack_box(MOST_POS, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG));

      for (int phase = 0; phase < $size(plan); phase++) begin
         @(negedge clock);
         wait_drained();
         @(posedge clock);
         load_view_matrix(plan[phase]);
         @(negedge clock);
         set_pace(pace_type'(phase % 4));
         repeat (PHASE_BOXES) box_queue.push_back(make_box());
      end

      @(negedge clock);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d boxes sent, %0d checked under %0d matrix loads, all four pacing modes",
               boxes_sent, verdicts_checked, matrix_loads);
      $display("%0d boxes culled; planes that rejected at least once: %b",
               culled_count, planes_seen);
      if (fail_count == 0) begin
         $display("aabb_frustum_cull_test: match");
      end else begin
         $display("aabb_frustum_cull_test: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/afc_pkg.sv
sv/afc_csr_regs.sv
sv/afc_product_stage.sv
sv/afc_corner_sum.sv
sv/afc_plane_test.sv
sv/aabb_frustum_cull_test.sv
sv/afc_port_checker.sv
dv/tb_aabb_frustum_cull_test.sv
